// ===== hw/rtl/ojq_pkg.sv =====
// Shared types, field widths and command codes for the ordered job queue.
package ojq_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam int MODE_W    = 3;
    localparam int TASK_ID_W = 16;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    // Operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NULL = 2'd3;

    // Index counter operations
    localparam logic [2:0] IDX_HOLD = 3'd0;
    localparam logic [2:0] IDX_LOAD = 3'd1;
    localparam logic [2:0] IDX_ZERO = 3'd2;
    localparam logic [2:0] IDX_INC  = 3'd3;
    localparam logic [2:0] IDX_DEC  = 3'd4;

    // Memory read address selection
    localparam logic [2:0] RD_IDX    = 3'd0;
    localparam logic [2:0] RD_IDX_M1 = 3'd1;
    localparam logic [2:0] RD_IDX_P1 = 3'd2;
    localparam logic [2:0] RD_FRONT  = 3'd3;
    localparam logic [2:0] RD_BACK   = 3'd4;

    // Memory write data selection
    localparam logic WR_SHIFT = 1'b0;
    localparam logic WR_NEW   = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [TASK_ID_W-1:0] task_id;
        logic [POS_W-1:0]     position;
    } job_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [TASK_ID_W-1:0] popped_id;
        logic [TASK_ID_W-1:0] front_id;
        logic [TASK_ID_W-1:0] back_id;
        logic [COUNT_W-1:0]   count;
    } result_t;

    typedef struct packed {
        logic                load;
        logic                st_wr;
        logic [STATUS_W-1:0] st_code;
        logic [2:0]          idx_op;
        logic                rd_en;
        logic [2:0]          rd_sel;
        logic                wr_en;
        logic                wr_sel;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                pop_cap;
        logic                front_cap;
        logic                out_load;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              id_null;
        logic              full;
        logic              empty;
        logic              at_tgt;
        logic              at_last;
        logic              hit;
        logic              out_free;
    } stat_t;

endpackage

// ===== hw/rtl/ojq_datapath.sv =====
// Datapath: entry memory, index counter, occupancy and result register.
module ojq_datapath
    import ojq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  job_t    job,
    input  cmd_t    cmd,
    output stat_t   stat,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic [TASK_ID_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]     cnt_reg,       cnt_next;
    logic                 res_valid_reg, res_valid_next;
    job_t                 job_reg,       job_next;
    logic [CNT_W-1:0]     idx_reg,       idx_next;
    logic [CNT_W-1:0]     tgt_reg,       tgt_next;
    logic [STATUS_W-1:0]  status_reg,    status_next;
    logic [TASK_ID_W-1:0] popped_reg,    popped_next;
    logic [TASK_ID_W-1:0] front_reg,     front_next;
    logic [TASK_ID_W-1:0] rdata_reg;
    result_t              res_reg,       res_next;

    logic [CNT_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     rd_addr;
    logic [TASK_ID_W-1:0] wr_data;
    logic                 cnt_zero;

    assign cnt_zero = (cnt_reg == '0);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_IDX:    rd_idx = idx_reg;
            RD_IDX_M1: rd_idx = idx_reg - CNT_W'(1);
            RD_IDX_P1: rd_idx = idx_reg + CNT_W'(1);
            RD_FRONT:  rd_idx = '0;
            RD_BACK:   rd_idx = cnt_reg - CNT_W'(1);
            default:   rd_idx = '0;
        endcase
    end

    assign rd_addr = rd_idx[IDX_W-1:0];
    assign wr_data = (cmd.wr_sel == WR_NEW) ? job_reg.task_id : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[idx_reg[IDX_W-1:0]] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        job_next    = cmd.load ? job : job_reg;
        status_next = cmd.st_wr ? cmd.st_code : status_reg;
        front_next  = cmd.front_cap ? rdata_reg : front_reg;

        popped_next = popped_reg;
        if (cmd.load)
        begin
            popped_next = '0;
        end
        else if (cmd.pop_cap)
        begin
            popped_next = rdata_reg;
        end

        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end

        idx_next = idx_reg;
        tgt_next = tgt_reg;
        unique case (cmd.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_LOAD:
            begin
                // Shift up from the back; an out-of-range position appends
                idx_next = cnt_reg;
                if (job_reg.mode == MODE_PUSH || 32'(job_reg.position) >= 32'(cnt_reg))
                begin
                    tgt_next = cnt_reg;
                end
                else
                begin
                    tgt_next = CNT_W'(job_reg.position);
                end
            end
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_reg + CNT_W'(1);
            IDX_DEC:  idx_next = idx_reg - CNT_W'(1);
            default:  idx_next = idx_reg;
        endcase

        res_next           = res_reg;
        res_next.status    = status_reg;
        res_next.popped_id = popped_reg;
        res_next.front_id  = cnt_zero ? '0 : front_reg;
        res_next.back_id   = cnt_zero ? '0 : rdata_reg;
        res_next.count     = COUNT_W'(cnt_reg);
        if (!cmd.out_load)
        begin
            res_next = res_reg;
        end

        res_valid_next = res_valid_reg;
        if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        idx_reg    <= idx_next;
        tgt_reg    <= tgt_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
        front_reg  <= front_next;
        res_reg    <= res_next;
    end

    assign stat.mode     = job_reg.mode;
    assign stat.id_null  = (job_reg.task_id == '0);
    assign stat.full     = (32'(cnt_reg) >= DEPTH);
    assign stat.empty    = cnt_zero;
    assign stat.at_tgt   = (idx_reg == tgt_reg);
    assign stat.at_last  = ((33'(idx_reg) + 33'd1) >= 33'(cnt_reg));
    assign stat.hit      = (rdata_reg == job_reg.task_id);
    assign stat.out_free = !res_valid_reg || !result_stall;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== hw/rtl/ojq_ctrl.sv =====
// Controller: sequences decode, search, shift and result read-back.
module ojq_ctrl
    import ojq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  job_valid,
    output logic  job_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_UP_CHK   = 4'd2;
    localparam logic [3:0] S_UP_WR    = 4'd3;
    localparam logic [3:0] S_SRCH_RD  = 4'd4;
    localparam logic [3:0] S_SRCH_CMP = 4'd5;
    localparam logic [3:0] S_POP_RD   = 4'd6;
    localparam logic [3:0] S_POP_CAP  = 4'd7;
    localparam logic [3:0] S_DN_CHK   = 4'd8;
    localparam logic [3:0] S_DN_WR    = 4'd9;
    localparam logic [3:0] S_FRONT_RD = 4'd10;
    localparam logic [3:0] S_BACK_RD  = 4'd11;
    localparam logic [3:0] S_FINISH   = 4'd12;

    logic [3:0] state_reg, state_next;

    assign job_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.idx_op = IDX_HOLD;
        cmd.rd_sel = RD_IDX;
        cmd.wr_sel = WR_SHIFT;

        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                cmd.st_wr   = 1'b1;
                cmd.st_code = ST_DONE;
                state_next  = S_FRONT_RD;
                unique case (stat.mode)
                    MODE_PUSH, MODE_INSERT:
                    begin
                        if (stat.id_null)
                        begin
                            cmd.st_code = ST_NULL;
                        end
                        else if (stat.full)
                        begin
                            cmd.st_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_LOAD;
                            state_next = S_UP_CHK;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (stat.id_null)
                        begin
                            cmd.st_code = ST_NULL;
                        end
                        else
                        begin
                            // Assume a miss until the search finds the identifier
                            cmd.st_code = ST_MISS;
                            if (!stat.empty)
                            begin
                                cmd.idx_op = IDX_ZERO;
                                state_next = S_SRCH_RD;
                            end
                        end
                    end
                    MODE_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.st_code = ST_MISS;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_POP_RD;
                        end
                    end
                    default:
                    begin
                        cmd.st_code = ST_DONE;
                    end
                endcase
            end

            S_UP_CHK:
            begin
                if (stat.at_tgt)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_NEW;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FRONT_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_M1;
                    state_next = S_UP_WR;
                end
            end

            S_UP_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_DEC;
                state_next = S_UP_CHK;
            end

            S_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
                state_next = S_SRCH_CMP;
            end

            S_SRCH_CMP:
            begin
                if (stat.hit)
                begin
                    cmd.st_wr   = 1'b1;
                    cmd.st_code = ST_DONE;
                    state_next  = S_DN_CHK;
                end
                else if (stat.at_last)
                begin
                    state_next = S_FRONT_RD;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_SRCH_RD;
                end
            end

            S_POP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_FRONT;
                state_next = S_POP_CAP;
            end

            S_POP_CAP:
            begin
                cmd.pop_cap = 1'b1;
                state_next  = S_DN_CHK;
            end

            S_DN_CHK:
            begin
                // Close the gap one entry at a time towards the back
                if (stat.at_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FRONT_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_P1;
                    state_next = S_DN_WR;
                end
            end

            S_DN_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_INC;
                state_next = S_DN_CHK;
            end

            S_FRONT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_FRONT;
                state_next = S_BACK_RD;
            end

            S_BACK_RD:
            begin
                cmd.front_cap = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RD_BACK;
                state_next    = S_FINISH;
            end

            S_FINISH:
            begin
                // Hold until the result register can take the transaction
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/ordered_job_queue.sv =====
// Top level of the ordered job queue: controller plus datapath.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  job      | job_valid / job_stall      | mode, task_id, position
//  result   | result_valid / result_stall| status, popped_id, front_id, back_id, count
//
// One transaction at a time; a new job is taken only while the controller is idle.
// A query or a rejected job is decoded, then the front and back entries are read and
// the result loaded. An insert first shifts entries up, a remove compares from the
// front and shifts later entries down on a hit, a pop captures the front and shifts down.
// Reset clears the occupancy count and the controller; entries are not cleared.
// A stalled result holds in the output register; a new job is taken meanwhile.
module ordered_job_queue
    import ojq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_stall,
    input  job_t    job,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    cmd_t  cmd;
    stat_t stat;

    ojq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_stall (job_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ojq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== bench/job_queue_checker.sv =====
`timescale 1ns / 1ps
// Checker for the ordered job queue: mirrors the queue, predicts and compares every result.
module job_queue_checker
    import ojq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    input  logic    job_stall,
    input  job_t    job,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      errors,
    output int      outstanding
);

    logic [TASK_ID_W-1:0] slots [DEPTH];
    int                   fill;
    result_t              expected_results [$];
    result_t              want;

    // Close the gap left at idx
    function automatic void take_slot(input int idx);
        for (int i = idx; i + 1 < fill; i++)
            slots[i] = slots[i + 1];
        fill--;
    endfunction

    // Apply one job to the mirrored queue and return the result it should produce
    function automatic result_t apply_job(input job_t j);
        result_t r;
        int      at;
        bit      found;
        r = '0;
        r.status = ST_DONE;
        case (j.mode)
            MODE_PUSH, MODE_INSERT:
            begin
                if (j.task_id == '0)
                    r.status = ST_NULL;
                else if (fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // positions at or past the back append
                    at = (j.mode == MODE_PUSH || j.position > fill) ? fill : int'(j.position);
                    for (int i = fill; i > at; i--)
                        slots[i] = slots[i - 1];
                    slots[at] = j.task_id;
                    fill++;
                end
            end
            MODE_REMOVE:
            begin
                if (j.task_id == '0)
                    r.status = ST_NULL;
                else
                begin
                    r.status = ST_MISS;
                    found = 1'b0;
                    // only the frontmost match goes
                    for (int i = 0; i < fill && !found; i++)
                    begin
                        if (slots[i] == j.task_id)
                        begin
                            take_slot(i);
                            r.status = ST_DONE;
                            found = 1'b1;
                        end
                    end
                end
            end
            MODE_POP:
            begin
                if (fill == 0)
                    r.status = ST_MISS;
                else
                begin
                    r.popped_id = slots[0];
                    take_slot(0);
                end
            end
            default:
            begin
            end
        endcase
        r.front_id = (fill > 0) ? slots[0] : '0;
        r.back_id  = (fill > 0) ? slots[fill - 1] : '0;
        r.count    = COUNT_W'(fill);
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] exp_val,
                                         input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = 0;
            expected_results.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (job_valid && !job_stall)
                expected_results.push_back(apply_job(job));
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %p", $time, result);
                    errors++;
                end
                else
                begin
                    // take the oldest prediction
                    want = expected_results[0];
                    expected_results.delete(0);
                    errors += field_differs("status", 32'(want.status), 32'(result.status))
                            + field_differs("popped_id", 32'(want.popped_id),
                                            32'(result.popped_id))
                            + field_differs("front_id", 32'(want.front_id),
                                            32'(result.front_id))
                            + field_differs("back_id", 32'(want.back_id), 32'(result.back_id))
                            + field_differs("count", 32'(want.count), 32'(result.count));
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== bench/ordered_job_queue_tb.sv =====
`timescale 1ns / 1ps
// Top of the ordered job queue testbench: clock, reset, job and result traffic, verdict.
module ordered_job_queue_tb;
    import ojq_pkg::*;

    localparam int CLOCK_LIMIT = 800000;
    localparam int RANDOM_JOBS = 1020;
    localparam int PRESSURE_AT = 60;
    localparam int HOLD_OFF    = 300;
    localparam int DRAIN       = 60;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_QUERY + 1'b1;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = '1;

    logic    clk;
    logic    rst_n;
    logic    job_valid;
    logic    job_stall;
    job_t    job;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    int errors;
    int outstanding;
    int jobs_sent;
    int cycle_count;
    bit calm;
    bit fill_lean;

    ordered_job_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_stall    (job_stall),
        .job          (job),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    job_queue_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_stall    (job_stall),
        .job          (job),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CLOCK_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ordered_job_queue_tb failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    function automatic job_t make_job(input logic [MODE_W-1:0] m,
                                      input logic [TASK_ID_W-1:0] id,
                                      input logic [POS_W-1:0] p);
        job_t j;
        j.mode     = m;
        j.task_id  = id;
        j.position = p;
        return j;
    endfunction

    function automatic job_t random_job();
        int               r;
        logic [MODE_W-1:0] m;
        logic [TASK_ID_W-1:0] id;
        logic [POS_W-1:0]  p;
        r = $urandom_range(0, 99);
        if (r >= 95)
            m = MODE_W'($urandom_range(int'(MODE_SPARE_LO), int'(MODE_SPARE_HI)));
        else if (r >= 90)
            m = MODE_QUERY;
        else if (fill_lean)
            m = (r < 35) ? MODE_PUSH : (r < 65) ? MODE_INSERT : (r < 80) ? MODE_REMOVE : MODE_POP;
        else
            m = (r < 10) ? MODE_PUSH : (r < 20) ? MODE_INSERT : (r < 55) ? MODE_REMOVE : MODE_POP;
        // a small pool of ids keeps removes hitting
        r = $urandom_range(0, 99);
        if (r < 85)
            id = TASK_ID_W'($urandom_range(1, 24));
        else if (r < 95)
            id = TASK_ID_W'($urandom());
        else
            id = '0;
        if ($urandom_range(0, 3) != 0)
            p = POS_W'($urandom_range(0, DEPTH - 1));
        else
            p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        return make_job(m, id, p);
    endfunction

    // Hold the transaction until taken, then, unless calm, idle for a random gap
    task automatic send_job(input job_t j);
        int gap;
        job       <= j;
        job_valid <= 1'b1;
        do
            @(posedge clk);
        while (job_stall);
        jobs_sent++;
        gap = calm ? 0 : idle_cycles();
        if (gap > 0)
        begin
            job_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result side: random stalls, one long hold-off to back the queue up
    initial
    begin
        int n;
        bit held;
        held = 1'b0;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && jobs_sent >= PRESSURE_AT)
            begin
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_OFF) @(posedge clk);
            end
            else
            begin
                n = idle_cycles();
                if (n > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            result_stall <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
            repeat (n) @(posedge clk);
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        job_valid <= 1'b0;
        job       <= '0;
        jobs_sent = 0;
        calm      = 1'b0;
        fill_lean = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue corner cases, then inserts at the front, past the back and in the middle
        send_job(make_job(MODE_QUERY, '0, '0));
        send_job(make_job(MODE_POP, 16'h0005, '0));
        send_job(make_job(MODE_REMOVE, 16'h0005, '0));
        send_job(make_job(MODE_PUSH, '0, '0));
        send_job(make_job(MODE_PUSH, 16'hFFFF, 5'h1F));
        send_job(make_job(MODE_INSERT, 16'h0001, '0));
        send_job(make_job(MODE_INSERT, 16'h8000, 5'h1F));
        send_job(make_job(MODE_INSERT, 16'h00AA, 5'd1));
        // duplicate id: remove takes the frontmost one
        send_job(make_job(MODE_PUSH, 16'h00AA, '0));
        send_job(make_job(MODE_REMOVE, 16'h00AA, '0));
        send_job(make_job(MODE_REMOVE, 16'h1234, '0));
        send_job(make_job(MODE_REMOVE, '0, '0));
        send_job(make_job(MODE_INSERT, '0, 5'd2));
        send_job(make_job(MODE_SPARE_LO, 16'h5A5A, 5'h15));
        send_job(make_job(MODE_SPARE_HI, 16'hA5A5, 5'h0A));
        send_job(make_job(MODE_POP, '0, '0));
        // fill up with one push too many, then an insert on the full queue and a null push
        for (int i = 0; i < 14; i++)
            send_job(make_job(MODE_PUSH, TASK_ID_W'(16'h0200 + i), '0));
        send_job(make_job(MODE_INSERT, 16'h0777, '0));
        send_job(make_job(MODE_PUSH, '0, '0));

        for (int k = 0; k < RANDOM_JOBS; k++)
        begin
            if (k % 48 == 0)
            begin
                fill_lean = $urandom_range(0, 1);
                calm      = ($urandom_range(0, 3) == 0);
            end
            send_job(random_job());
        end
        job_valid <= 1'b0;

        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("ordered_job_queue_tb passed");
        else
            $display("ordered_job_queue_tb failed");
        $finish;
    end

endmodule
